>>> src/qri_pkg.sv
// Shared types, widths, constants and term tables of the quaternion rate integration core.
package qri_pkg;

   // Fixed field widths
   localparam int RATE_WIDTH = 32;
   localparam int STEP_WIDTH = 32;

   // Internal datapath widths
   localparam int HALF_WIDTH  = 31;   // half-angle, Q3.28
   localparam int S2_WIDTH    = 32;   // s2, Q2.30
   localparam int S2SQ_WIDTH  = 34;   // s2 squared, Q4.30
   localparam int COS_WIDTH   = 34;   // signed c, Q.30
   localparam int COEF_WIDTH  = 44;   // magnitude of c or u*rate, Q.30
   localparam int SPLIT_WIDTH = 22;   // low slice of a coefficient magnitude
   localparam int PROD_SHIFT  = 30;   // scaling of each quaternion term

   // Pipeline partitioning
   localparam int ANGLE_STAGES  = 3;
   localparam int COEFF_STAGES  = 4;
   localparam int ROTATE_STAGES = 4;
   localparam int PIPE_STAGES   = ANGLE_STAGES + COEFF_STAGES + ROTATE_STAGES;

   // Arithmetic constants
   localparam logic [HALF_WIDTH-1:0] HALF_ANGLE_MAX = '1;
   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [31:0] RECIP_3  = 32'hAAAA_AAAB;   // ceil(2^33 / 3)
   localparam logic [31:0] RECIP_15 = 32'h8888_8889;   // ceil(2^35 / 15)

   typedef logic signed [RATE_WIDTH-1:0] rate_type;
   typedef logic [STEP_WIDTH-1:0]        step_type;

   typedef enum logic [1:0] {COEF_C, COEF_VX, COEF_VY, COEF_VZ} coef_sel_type;
   typedef enum logic [1:0] {QSEL_W, QSEL_X, QSEL_Y, QSEL_Z} quat_sel_type;

   // Term tables: component j is the signed sum over k of coef[j][k] * q[j][k]
   localparam coef_sel_type TERM_COEF [4][4] = '{
      '{COEF_C, COEF_VX, COEF_VY, COEF_VZ},
      '{COEF_C, COEF_VX, COEF_VZ, COEF_VY},
      '{COEF_C, COEF_VY, COEF_VZ, COEF_VX},
      '{COEF_C, COEF_VZ, COEF_VY, COEF_VX}
   };
   localparam quat_sel_type TERM_QUAT [4][4] = '{
      '{QSEL_W, QSEL_X, QSEL_Y, QSEL_Z},
      '{QSEL_X, QSEL_W, QSEL_Y, QSEL_Z},
      '{QSEL_Y, QSEL_W, QSEL_X, QSEL_Z},
      '{QSEL_Z, QSEL_W, QSEL_X, QSEL_Y}
   };
   localparam logic TERM_NEG [4][4] = '{
      '{1'b0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 1'b0, 1'b0, 1'b1},
      '{1'b0, 1'b0, 1'b1, 1'b0},
      '{1'b0, 1'b0, 1'b0, 1'b1}
   };

   // Magnitude of a signed rate; the most negative value maps to 2^31
   function automatic logic [RATE_WIDTH-1:0] rate_mag(input rate_type r);
      logic [RATE_WIDTH-1:0] m;
      m = r[RATE_WIDTH-1] ? RATE_WIDTH'(-r) : RATE_WIDTH'(r);
      return m;
   endfunction

endpackage

>>> src/qri_angle.sv
// Half-angle products, their squares and the saturated rotation measure s2.
module qri_angle import qri_pkg::*; #(
   parameter int QUAT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic [ANGLE_STAGES-1:0]      advance,
   input  logic signed [QUAT_WIDTH-1:0] src_quat [4],
   input  rate_type                     src_rate [3],
   input  step_type                     src_step,
   output logic [S2_WIDTH-1:0]          fwd_s2,
   output logic signed [QUAT_WIDTH-1:0] fwd_quat [4],
   output rate_type                     fwd_rate [3],
   output step_type                     fwd_step
);

   logic signed [QUAT_WIDTH-1:0] quat_ff [ANGLE_STAGES][4];
   rate_type                     rate_ff [ANGLE_STAGES][3];
   step_type                     step_ff [ANGLE_STAGES];

   logic [63:0]           hprod_in [3];
   logic [63:0]           hprod_ff [3];
   logic [HALF_WIDTH-1:0] half_ang [3];
   logic [61:0]           hsq_in [3];
   logic [61:0]           hsq_ff [3];
   logic [63:0]           hsum;
   logic [S2_WIDTH-1:0]   s2_in;
   logic [S2_WIDTH-1:0]   s2_ff;

   // Stage 0: |rate| * dt
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hprod_in[i] = 64'(rate_mag(src_rate[i])) * 64'(src_step);
      end
   end

   // Stage 1: half-angle, held at its maximum, then squared
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         half_ang[i] = (|hprod_ff[i][63:52]) ? HALF_ANGLE_MAX : hprod_ff[i][51:21];
         hsq_in[i]   = 62'(half_ang[i]) * 62'(half_ang[i]);
      end
   end

   // Stage 2: sum of squares, rescaled and held at the s2 maximum
   always_comb begin
      hsum  = 64'(hsq_ff[0]) + 64'(hsq_ff[1]) + 64'(hsq_ff[2]);
      s2_in = (|hsum[63:58]) ? '1 : hsum[57:26];
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         hprod_ff   <= hprod_in;
         quat_ff[0] <= src_quat;
         rate_ff[0] <= src_rate;
         step_ff[0] <= src_step;
      end
      if (advance[1]) begin
         hsq_ff <= hsq_in;
      end
      if (advance[2]) begin
         s2_ff <= s2_in;
      end
      for (int k = 1; k < ANGLE_STAGES; k++) begin
         if (advance[k]) begin
            quat_ff[k] <= quat_ff[k-1];
            rate_ff[k] <= rate_ff[k-1];
            step_ff[k] <= step_ff[k-1];
         end
      end
   end

   assign fwd_s2   = s2_ff;
   assign fwd_quat = quat_ff[ANGLE_STAGES-1];
   assign fwd_rate = rate_ff[ANGLE_STAGES-1];
   assign fwd_step = step_ff[ANGLE_STAGES-1];

endmodule

>>> src/qri_coeff.sv
// Series coefficients c and u from s2, with constant divisions done by reciprocals.
module qri_coeff import qri_pkg::*; #(
   parameter int QUAT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic [COEFF_STAGES-1:0]      advance,
   input  logic [S2_WIDTH-1:0]          src_s2,
   input  logic signed [QUAT_WIDTH-1:0] src_quat [4],
   input  rate_type                     src_rate [3],
   input  step_type                     src_step,
   output logic signed [COS_WIDTH-1:0]  fwd_c,
   output logic [31:0]                  fwd_u,
   output logic signed [QUAT_WIDTH-1:0] fwd_quat [4],
   output rate_type                     fwd_rate [3]
);

   logic signed [QUAT_WIDTH-1:0] quat_ff [COEFF_STAGES][4];
   rate_type                     rate_ff [COEFF_STAGES][3];
   step_type                     step_ff [COEFF_STAGES-1];

   logic [63:0]           s2sq_prod;
   logic [S2SQ_WIDTH-1:0] s2sq_in;
   logic [S2SQ_WIDTH-1:0] s2sq_ff;
   logic [31:0]           half_in;
   logic [31:0]           half_ff [2];
   logic [63:0]           d6_prod;
   logic [31:0]           d6_in;
   logic [31:0]           d6_ff [2];

   logic [30:0]           s2sq_8;
   logic [63:0]           d24_prod;
   logic [63:0]           d120_prod;
   logic [31:0]           d24_in;
   logic [31:0]           d24_ff;
   logic [31:0]           d120_in;
   logic [31:0]           d120_ff;

   logic signed [COS_WIDTH-1:0] c_in;
   logic signed [COS_WIDTH-1:0] c_ff [2];
   logic [31:0]           g_in;
   logic [31:0]           g_ff;

   logic [63:0]           u_prod;
   logic [31:0]           u_in;
   logic [31:0]           u_ff;

   // Stage 0: s2 squared, s2/2 and s2/6
   always_comb begin
      s2sq_prod = 64'(src_s2) * 64'(src_s2);
      s2sq_in   = s2sq_prod[63:30];
      half_in   = {1'b0, src_s2[S2_WIDTH-1:1]};
      d6_prod   = 64'(half_in) * 64'(RECIP_3);
      d6_in     = {1'b0, d6_prod[63:33]};
   end

   // Stage 1: s2sq/24 and s2sq/120 via s2sq/8
   always_comb begin
      s2sq_8    = s2sq_ff[S2SQ_WIDTH-1:3];
      d24_prod  = 64'(s2sq_8) * 64'(RECIP_3);
      d120_prod = 64'(s2sq_8) * 64'(RECIP_15);
      d24_in    = {1'b0, d24_prod[63:33]};
      d120_in   = {3'b000, d120_prod[63:35]};
   end

   // Stage 2: c and g
   always_comb begin
      c_in = $signed({2'b00, ONE_Q30}) - $signed({2'b00, half_ff[1]})
           + $signed({2'b00, d24_ff});
      g_in = ONE_Q30 - d6_ff[1] + d120_ff;
   end

   // Stage 3: u = dt * g / 2
   always_comb begin
      u_prod = 64'(step_ff[COEFF_STAGES-2]) * 64'(g_ff);
      u_in   = u_prod[62:31];
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         s2sq_ff    <= s2sq_in;
         half_ff[0] <= half_in;
         d6_ff[0]   <= d6_in;
         quat_ff[0] <= src_quat;
         rate_ff[0] <= src_rate;
         step_ff[0] <= src_step;
      end
      if (advance[1]) begin
         d24_ff     <= d24_in;
         d120_ff    <= d120_in;
         half_ff[1] <= half_ff[0];
         d6_ff[1]   <= d6_ff[0];
      end
      if (advance[2]) begin
         c_ff[0] <= c_in;
         g_ff    <= g_in;
      end
      if (advance[3]) begin
         u_ff    <= u_in;
         c_ff[1] <= c_ff[0];
      end
      for (int k = 1; k < COEFF_STAGES; k++) begin
         if (advance[k]) begin
            quat_ff[k] <= quat_ff[k-1];
            rate_ff[k] <= rate_ff[k-1];
         end
      end
      for (int k = 1; k < COEFF_STAGES - 1; k++) begin
         if (advance[k]) begin
            step_ff[k] <= step_ff[k-1];
         end
      end
   end

   assign fwd_c    = c_ff[1];
   assign fwd_u    = u_ff;
   assign fwd_quat = quat_ff[COEFF_STAGES-1];
   assign fwd_rate = rate_ff[COEFF_STAGES-1];

endmodule

>>> src/qri_rotate.sv
// Sixteen quaternion terms as split partial products, summed and saturated per component.
module qri_rotate import qri_pkg::*; #(
   parameter int QUAT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic [ROTATE_STAGES-1:0]     advance,
   input  logic signed [COS_WIDTH-1:0]  src_c,
   input  logic [31:0]                  src_u,
   input  logic signed [QUAT_WIDTH-1:0] src_quat [4],
   input  rate_type                     src_rate [3],
   output logic signed [QUAT_WIDTH-1:0] new_quat [4],
   output logic                         clipped
);

   localparam int PROD_WIDTH = SPLIT_WIDTH + QUAT_WIDTH;
   localparam int FULL_WIDTH = COEF_WIDTH + QUAT_WIDTH;
   localparam int MAG_WIDTH  = FULL_WIDTH - PROD_SHIFT;
   localparam int TERM_WIDTH = MAG_WIDTH + 1;
   localparam int ACC_WIDTH  = TERM_WIDTH + 2;
   localparam logic signed [QUAT_WIDTH-1:0] QUAT_MAX = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
   localparam logic signed [QUAT_WIDTH-1:0] QUAT_MIN = {1'b1, {(QUAT_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_WIDTH-1:0]  ACC_MAX  = ACC_WIDTH'(QUAT_MAX);
   localparam logic signed [ACC_WIDTH-1:0]  ACC_MIN  = ACC_WIDTH'(QUAT_MIN);

   logic [63:0]                 v_prod [3];
   logic [COS_WIDTH-1:0]        c_abs;
   logic [COEF_WIDTH-1:0]       coef_mag_in [4];
   logic [COEF_WIDTH-1:0]       coef_mag_ff [4];
   logic                        coef_neg_in [4];
   logic                        coef_neg_ff [4];
   logic [QUAT_WIDTH-1:0]       qmag_in [4];
   logic [QUAT_WIDTH-1:0]       qmag_ff [4];
   logic                        qneg_in [4];
   logic                        qneg_ff [4];

   logic [PROD_WIDTH-1:0]       lo_in [4][4];
   logic [PROD_WIDTH-1:0]       lo_ff [4][4];
   logic [PROD_WIDTH-1:0]       hi_in [4][4];
   logic [PROD_WIDTH-1:0]       hi_ff [4][4];
   logic                        neg_in [4][4];
   logic                        neg_ff [4][4];

   logic [FULL_WIDTH-1:0]       full_prod [4][4];
   logic [MAG_WIDTH-1:0]        term_mag [4][4];
   logic signed [TERM_WIDTH-1:0] term_in [4][4];
   logic signed [TERM_WIDTH-1:0] term_ff [4][4];

   logic signed [ACC_WIDTH-1:0] acc [4];
   logic signed [QUAT_WIDTH-1:0] new_quat_in [4];
   logic signed [QUAT_WIDTH-1:0] new_quat_ff [4];
   logic                        clip_in;
   logic                        clip_ff;

   // Stage 0: v = u * rate, split every operand into sign and magnitude
   always_comb begin
      c_abs          = src_c[COS_WIDTH-1] ? COS_WIDTH'(-src_c) : COS_WIDTH'(src_c);
      coef_mag_in[0] = COEF_WIDTH'(c_abs);
      coef_neg_in[0] = src_c[COS_WIDTH-1];
      for (int i = 0; i < 3; i++) begin
         v_prod[i]        = 64'(src_u) * 64'(rate_mag(src_rate[i]));
         coef_mag_in[i+1] = v_prod[i][61:18];
         coef_neg_in[i+1] = src_rate[i][RATE_WIDTH-1];
      end
      for (int j = 0; j < 4; j++) begin
         qmag_in[j] = src_quat[j][QUAT_WIDTH-1] ? QUAT_WIDTH'(-src_quat[j])
                                                : QUAT_WIDTH'(src_quat[j]);
         qneg_in[j] = src_quat[j][QUAT_WIDTH-1];
      end
   end

   // Stage 1: low and high partial products of every term, with its final sign
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 4; k++) begin
            lo_in[j][k]  = PROD_WIDTH'(coef_mag_ff[TERM_COEF[j][k]][SPLIT_WIDTH-1:0])
                         * PROD_WIDTH'(qmag_ff[TERM_QUAT[j][k]]);
            hi_in[j][k]  = PROD_WIDTH'(coef_mag_ff[TERM_COEF[j][k]][COEF_WIDTH-1:SPLIT_WIDTH])
                         * PROD_WIDTH'(qmag_ff[TERM_QUAT[j][k]]);
            neg_in[j][k] = coef_neg_ff[TERM_COEF[j][k]] ^ qneg_ff[TERM_QUAT[j][k]]
                         ^ TERM_NEG[j][k];
         end
      end
   end

   // Stage 2: rebuild each product, rescale toward zero, apply the sign
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         for (int k = 0; k < 4; k++) begin
            full_prod[j][k] = (FULL_WIDTH'(hi_ff[j][k]) << SPLIT_WIDTH)
                            + FULL_WIDTH'(lo_ff[j][k]);
            term_mag[j][k]  = full_prod[j][k][FULL_WIDTH-1:PROD_SHIFT];
            term_in[j][k]   = neg_ff[j][k] ? -$signed({1'b0, term_mag[j][k]})
                                           :  $signed({1'b0, term_mag[j][k]});
         end
      end
   end

   // Stage 3: exact sum of four terms, saturated to the quaternion format
   always_comb begin
      clip_in = 1'b0;
      for (int j = 0; j < 4; j++) begin
         acc[j] = ACC_WIDTH'(term_ff[j][0]) + ACC_WIDTH'(term_ff[j][1])
                + ACC_WIDTH'(term_ff[j][2]) + ACC_WIDTH'(term_ff[j][3]);
         priority if (acc[j] > ACC_MAX) begin
            new_quat_in[j] = QUAT_MAX;
            clip_in        = 1'b1;
         end else if (acc[j] < ACC_MIN) begin
            new_quat_in[j] = QUAT_MIN;
            clip_in        = 1'b1;
         end else begin
            new_quat_in[j] = acc[j][QUAT_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         coef_mag_ff <= coef_mag_in;
         coef_neg_ff <= coef_neg_in;
         qmag_ff     <= qmag_in;
         qneg_ff     <= qneg_in;
      end
      if (advance[1]) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         neg_ff <= neg_in;
      end
      if (advance[2]) begin
         term_ff <= term_in;
      end
      if (advance[3]) begin
         new_quat_ff <= new_quat_in;
         clip_ff     <= clip_in;
      end
   end

   assign new_quat = new_quat_ff;
   assign clipped  = clip_ff;

endmodule

>>> src/quaternion_rate_integration_core.sv
// Top level of the quaternion rate integration core: handshake, valid chain and datapath.
//
// Propagates an attitude quaternion by body rates over a time step, using the
// second-order series of the exponential map, and saturates the result.
// Request channel (req_*): quaternion (signed Q2.30 at the default width),
// rates (signed Q16.16 rad/s) and time step (unsigned Q0.32 s), taken when
// req_valid and req_ready are both high.
// Response channel (rsp_*): propagated quaternion and a clipped flag, taken
// when rsp_valid and rsp_ready are both high. One response per request, in order.
// Structure: 11 pipeline registers (three for s2, four for the coefficients c and u,
// four for the product terms); the valid bit of an accepted request travels through
// them with its data, and rsp_valid is the valid bit of the last register.
// Throughput: one request per cycle unless rsp_ready stalls the 11-stage pipeline.
// Stalls: each stage holds while its successor is full and stalled; empty
// stages keep filling, so bubbles close up and req_ready drops only when every
// stage holds a request. Nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline; there is no other state
// and no configuration.
module quaternion_rate_integration_core import qri_pkg::*; #(
   parameter int QUAT_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_w,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_x,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_y,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_z,
   input  rate_type                     req_rate_x,
   input  rate_type                     req_rate_y,
   input  rate_type                     req_rate_z,
   input  step_type                     req_step_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [QUAT_WIDTH-1:0] rsp_new_w,
   output logic signed [QUAT_WIDTH-1:0] rsp_new_x,
   output logic signed [QUAT_WIDTH-1:0] rsp_new_y,
   output logic signed [QUAT_WIDTH-1:0] rsp_new_z,
   output logic                         rsp_clipped
);

   localparam int COEFF_BASE  = ANGLE_STAGES;
   localparam int ROTATE_BASE = ANGLE_STAGES + COEFF_STAGES;
   localparam logic signed [QUAT_WIDTH-1:0] QUAT_MAX = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
   localparam logic signed [QUAT_WIDTH-1:0] QUAT_MIN = {1'b1, {(QUAT_WIDTH-1){1'b0}}};

   logic [PIPE_STAGES-1:0] vld_ff;
   logic [PIPE_STAGES-1:0] adv;

   logic signed [QUAT_WIDTH-1:0] req_quat [4];
   rate_type                     req_rate [3];

   logic [S2_WIDTH-1:0]          ang_s2;
   logic signed [QUAT_WIDTH-1:0] ang_quat [4];
   rate_type                     ang_rate [3];
   step_type                     ang_step;

   logic signed [COS_WIDTH-1:0]  cf_c;
   logic [31:0]                  cf_u;
   logic signed [QUAT_WIDTH-1:0] cf_quat [4];
   rate_type                     cf_rate [3];

   logic signed [QUAT_WIDTH-1:0] rot_quat [4];

   // A stage may load when it is empty or its content moves on
   assign adv[PIPE_STAGES-1] = rsp_ready | ~vld_ff[PIPE_STAGES-1];
   for (genvar k = 0; k < PIPE_STAGES - 1; k++) begin : g_adv
      assign adv[k] = adv[k+1] | ~vld_ff[k];
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < PIPE_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[PIPE_STAGES-1];

   assign req_quat = '{req_quat_w, req_quat_x, req_quat_y, req_quat_z};
   assign req_rate = '{req_rate_x, req_rate_y, req_rate_z};

   qri_angle #(.QUAT_WIDTH(QUAT_WIDTH)) u_angle (
      .clock    (clock),
      .advance  (adv[ANGLE_STAGES-1:0]),
      .src_quat (req_quat),
      .src_rate (req_rate),
      .src_step (req_step_time),
      .fwd_s2   (ang_s2),
      .fwd_quat (ang_quat),
      .fwd_rate (ang_rate),
      .fwd_step (ang_step)
   );

   qri_coeff #(.QUAT_WIDTH(QUAT_WIDTH)) u_coeff (
      .clock    (clock),
      .advance  (adv[ROTATE_BASE-1:COEFF_BASE]),
      .src_s2   (ang_s2),
      .src_quat (ang_quat),
      .src_rate (ang_rate),
      .src_step (ang_step),
      .fwd_c    (cf_c),
      .fwd_u    (cf_u),
      .fwd_quat (cf_quat),
      .fwd_rate (cf_rate)
   );

   qri_rotate #(.QUAT_WIDTH(QUAT_WIDTH)) u_rotate (
      .clock    (clock),
      .advance  (adv[PIPE_STAGES-1:ROTATE_BASE]),
      .src_c    (cf_c),
      .src_u    (cf_u),
      .src_quat (cf_quat),
      .src_rate (cf_rate),
      .new_quat (rot_quat),
      .clipped  (rsp_clipped)
   );

   assign rsp_new_w = rot_quat[0];
   assign rsp_new_x = rot_quat[1];
   assign rsp_new_y = rot_quat[2];
   assign rsp_new_z = rot_quat[3];

   // An accepted request occupies the first stage
   a_accept_fills : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // A full stage that cannot move keeps its request
   a_hold_no_loss : assert property (@(posedge clock) disable iff (reset)
      (vld_ff & ~adv) != '0 |=>
         ((vld_ff & $past(vld_ff & ~adv)) == $past(vld_ff & ~adv)))
      else $error("stalled pipeline stage dropped its request");

   // A request moving forward lands in the next stage
   a_advance_moves : assert property (@(posedge clock) disable iff (reset)
      (adv[PIPE_STAGES-1:1] & vld_ff[PIPE_STAGES-2:0]) != '0 |=>
         ((vld_ff[PIPE_STAGES-1:1] & $past(adv[PIPE_STAGES-1:1] & vld_ff[PIPE_STAGES-2:0]))
          == $past(adv[PIPE_STAGES-1:1] & vld_ff[PIPE_STAGES-2:0])))
      else $error("request lost between pipeline stages");

   // The clip flag only accompanies a component held at a limit
   a_clip_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (rsp_new_w == QUAT_MAX) || (rsp_new_w == QUAT_MIN) ||
         (rsp_new_x == QUAT_MAX) || (rsp_new_x == QUAT_MIN) ||
         (rsp_new_y == QUAT_MAX) || (rsp_new_y == QUAT_MIN) ||
         (rsp_new_z == QUAT_MAX) || (rsp_new_z == QUAT_MIN))
      else $error("clipped set without a saturated component");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the quaternion rate integration core.
`timescale 1ns / 100ps

module tb_top import qri_pkg::*; ();

   localparam int     QW          = 32;
   localparam longint QUAT_MAX    = 64'sd2147483647;
   localparam longint QUAT_MIN    = -QUAT_MAX - 1;
   localparam int     CYCLE_LIMIT = 400_000;
   localparam int     GAP_MAX     = 64;
   localparam int     N_RANDOM    = 1600;
   localparam int     N_DIRECTED  = 20;

   // One request and one propagated result as the testbench holds them
   typedef struct packed {
      logic [QW-1:0] qw, qx, qy, qz;
      logic [31:0]   rx, ry, rz;
      logic [31:0]   dt;
   } rate_request_type;

   typedef struct packed {
      logic [QW-1:0] w, x, y, z;
      logic          clip;
   } quat_result_type;

   typedef struct packed {
      rate_request_type req;
      logic             typed;
      quat_result_type  res;
   } vector_type;

   localparam quat_result_type NO_RESULT = '0;

   // Directed requests; rows with typed results carry their expected result in the table
   localparam vector_type VECTORS [N_DIRECTED] = '{
      // all zero
      '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
        '{32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
      // identity, no rotation
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
        '{32'h4000_0000, 32'h0, 32'h0, 32'h0, 1'b0}},
      // zero time step, largest fields everywhere else
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0}, 1'b1,
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}},
      // zero time step, most negative fields
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0}, 1'b1,
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}},
      // zero rates, longest step: quaternion passes unchanged
      '{'{32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 32'hF0F0_F0F1,
          32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
        '{32'h1234_5678, 32'hEDCB_A988, 32'h0F0F_0F0F, 32'hF0F0_F0F1, 1'b0}},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
          32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, 1'b1,
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}},
      // single-axis rotations of the identity, then a three-axis rotation of a unit x quaternion
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
          32'h0100_0000}, 1'b0, NO_RESULT},
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 32'h0,
          32'h0100_0000}, 1'b0, NO_RESULT},
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0008_0000,
          32'h0040_0000}, 1'b0, NO_RESULT},
      '{'{32'h0, 32'h4000_0000, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFE_0000,
          32'h0003_0000, 32'h0200_0000}, 1'b0, NO_RESULT},
      // rotation per step so large that s2 holds at its ceiling
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
      '{'{32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h8000_0000,
          32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
      // non-unit quaternion driven past full scale: positive then negative clip
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
          32'h0100_0000}, 1'b0, NO_RESULT},
      '{'{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0,
          32'h0100_0000}, 1'b0, NO_RESULT},
      '{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0010_0000}, 1'b0, NO_RESULT},
      // shortest non-zero step
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h0000_0001}, 1'b0, NO_RESULT},
      '{'{32'h2D41_3CCD, 32'h2D41_3CCD, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
          32'h0001_0000, 32'h8000_0000}, 1'b0, NO_RESULT},
      '{'{32'h0, 32'h0, 32'h0, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, NO_RESULT},
      '{'{32'h3FFF_FFFF, 32'hC000_0001, 32'h3FFF_FFFF, 32'hC000_0001, 32'h0020_0000,
          32'hFFE0_0000, 32'h0010_0000, 32'h0040_0000}, 1'b0, NO_RESULT},
      '{'{32'h4000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
          32'h0000_1000}, 1'b0, NO_RESULT}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [QW-1:0]  req_quat_w = '0;
   logic signed [QW-1:0]  req_quat_x = '0;
   logic signed [QW-1:0]  req_quat_y = '0;
   logic signed [QW-1:0]  req_quat_z = '0;
   rate_type              req_rate_x = '0;
   rate_type              req_rate_y = '0;
   rate_type              req_rate_z = '0;
   step_type              req_step_time = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [QW-1:0]  rsp_new_w;
   logic signed [QW-1:0]  rsp_new_x;
   logic signed [QW-1:0]  rsp_new_y;
   logic signed [QW-1:0]  rsp_new_z;
   logic                  rsp_clipped;

   quat_result_type pending_quats [$];
   int send_idle_pct = 16;
   int recv_idle_pct = 47;
   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int clipped_count = 0;
   int cycle_count   = 0;

   quaternion_rate_integration_core #(.QUAT_WIDTH(QW)) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_quat_w    (req_quat_w),
      .req_quat_x    (req_quat_x),
      .req_quat_y    (req_quat_y),
      .req_quat_z    (req_quat_z),
      .req_rate_x    (req_rate_x),
      .req_rate_y    (req_rate_y),
      .req_rate_z    (req_rate_z),
      .req_step_time (req_step_time),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_new_w     (rsp_new_w),
      .rsp_new_x     (rsp_new_x),
      .rsp_new_y     (rsp_new_y),
      .rsp_new_z     (rsp_new_z),
      .rsp_clipped   (rsp_clipped)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Signed (a*b) >> sh, truncated towards zero, over the full 128-bit product
   function automatic longint mul_trunc(input longint a, input longint b, input int sh);
      logic [63:0]  ma, mb, m;
      logic [127:0] p;
      ma = (a < 0) ? 64'(-a) : 64'(a);
      mb = (b < 0) ? 64'(-b) : 64'(b);
      p  = {64'd0, ma} * {64'd0, mb};
      m  = 64'(p >> sh);
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // Second-order series propagation of one request, with output saturation
   function automatic quat_result_type propagate_quat(input rate_request_type r);
      longint       q [4];
      longint       rt [3];
      longint       v [3];
      longint       acc [4];
      longint       c;
      logic [63:0]  dt, mag, h, sum, s2, s2sq, g, u;
      logic [QW-1:0] comp [4];
      quat_result_type res;
      q[0]  = longint'($signed(r.qw));
      q[1]  = longint'($signed(r.qx));
      q[2]  = longint'($signed(r.qy));
      q[3]  = longint'($signed(r.qz));
      rt[0] = longint'($signed(r.rx));
      rt[1] = longint'($signed(r.ry));
      rt[2] = longint'($signed(r.rz));
      dt    = {32'd0, r.dt};
      res.clip = 1'b0;

      // half-angles, held at their ceiling, then s2 and its square
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         mag = (rt[i] < 0) ? 64'(-rt[i]) : 64'(rt[i]);
         h   = (mag * dt) >> 21;
         if (h > 64'h7FFF_FFFF) h = 64'h7FFF_FFFF;
         sum = sum + h * h;
      end
      s2 = sum >> 26;
      if (s2 > 64'hFFFF_FFFF) s2 = 64'hFFFF_FFFF;
      s2sq = (s2 * s2) >> 30;

      // series coefficients
      c = longint'(64'd1 << 30) - longint'(s2 >> 1) + longint'(s2sq / 24);
      g = (64'd1 << 30) - s2 / 6 + s2sq / 120;
      u = (dt * g) >> 31;
      for (int i = 0; i < 3; i++)
         v[i] = mul_trunc(longint'(u), rt[i], 18);

      // c*q - u*M*q
      acc[0] = mul_trunc(c, q[0], 30) - mul_trunc(v[0], q[1], 30)
             - mul_trunc(v[1], q[2], 30) - mul_trunc(v[2], q[3], 30);
      acc[1] = mul_trunc(c, q[1], 30) + mul_trunc(v[0], q[0], 30)
             + mul_trunc(v[2], q[2], 30) - mul_trunc(v[1], q[3], 30);
      acc[2] = mul_trunc(c, q[2], 30) + mul_trunc(v[1], q[0], 30)
             - mul_trunc(v[2], q[1], 30) + mul_trunc(v[0], q[3], 30);
      acc[3] = mul_trunc(c, q[3], 30) + mul_trunc(v[2], q[0], 30)
             + mul_trunc(v[1], q[1], 30) - mul_trunc(v[0], q[2], 30);

      for (int k = 0; k < 4; k++) begin
         if (acc[k] > QUAT_MAX) begin
            acc[k]   = QUAT_MAX;
            res.clip = 1'b1;
         end
         if (acc[k] < QUAT_MIN) begin
            acc[k]   = QUAT_MIN;
            res.clip = 1'b1;
         end
         comp[k] = acc[k][QW-1:0];
      end
      res.w = comp[0];
      res.x = comp[1];
      res.y = comp[2];
      res.z = comp[3];
      return res;
   endfunction

   // Log-spread magnitude with random sign
   function automatic logic [31:0] spread_value();
      logic [31:0] r;
      r = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 1) == 1) r = -r;
      return r;
   endfunction

   function automatic logic [31:0] corner_value();
      unique case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0001;
         4: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Component within [-1.0, 1.0)
   function automatic logic [QW-1:0] attitude_component();
      logic [31:0] t;
      t = $urandom;
      return {{2{t[31]}}, t[29:0]};
   endfunction

   function automatic rate_request_type random_request();
      rate_request_type r;
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         // plausible attitude, rates over the whole scale, mostly short steps
         r.qw = attitude_component();
         r.qx = attitude_component();
         r.qy = attitude_component();
         r.qz = attitude_component();
         r.rx = spread_value();
         r.ry = spread_value();
         r.rz = spread_value();
         r.dt = $urandom >> $urandom_range(4, 31);
      end else if (mode < 9) begin
         r = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else begin
         r = {corner_value(), corner_value(), corner_value(), corner_value(),
              corner_value(), corner_value(), corner_value(), corner_value()};
      end
      return r;
   endfunction

   // Present one request and hold it until accepted, then queue its result
   task automatic push_request(input rate_request_type r, input logic typed,
                               input quat_result_type fixed);
      req_valid     <= 1'b1;
      req_quat_w    <= r.qw;
      req_quat_x    <= r.qx;
      req_quat_y    <= r.qy;
      req_quat_z    <= r.qz;
      req_rate_x    <= r.rx;
      req_rate_y    <= r.ry;
      req_rate_z    <= r.rz;
      req_step_time <= r.dt;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_quats.insert(pending_quats.size(), typed ? fixed : propagate_quat(r));
      sent_count++;
   endtask

   // Random idle cycles between requests, with junk on the payload
   task automatic sender_gap();
      int n;
      n = 0;
      while (n < GAP_MAX && $urandom_range(0, 99) < send_idle_pct) n++;
      if (n > 0) begin
         req_valid     <= 1'b0;
         req_quat_w    <= $urandom;
         req_rate_x    <= $urandom;
         req_step_time <= $urandom;
         repeat (n) @(posedge clock);
      end
   endtask

   // Response side: random back-pressure and in-order comparison
   always @(posedge clock) begin : rsp_monitor
      quat_result_type want, got;
      logic [QW-1:0] wv [4];
      logic [QW-1:0] gv [4];
      string names;
      names = "wxyz";
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_new_w, rsp_new_x, rsp_new_y, rsp_new_z, rsp_clipped};
         if (pending_quats.size() == 0) begin
            $display("%0t: unexpected response new_w=%h new_x=%h new_y=%h new_z=%h clipped=%b",
                     $time, got.w, got.x, got.y, got.z, got.clip);
            error_count++;
         end else begin
            want = pending_quats.pop_front();
            wv   = '{want.w, want.x, want.y, want.z};
            gv   = '{got.w, got.x, got.y, got.z};
            for (int k = 0; k < 4; k++) begin
               if (gv[k] !== wv[k]) begin
                  $display("%0t: new_%c expected %h, actual %h",
                           $time, names[k], wv[k], gv[k]);
                  error_count++;
               end
            end
            if (got.clip !== want.clip) begin
               $display("%0t: clipped expected %b, actual %b", $time, want.clip, got.clip);
               error_count++;
            end
            checked_count++;
            if (want.clip) clipped_count++;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_quats.size());
         $display("quaternion_rate_integration_core: mismatch");
         $finish;
      end
   end

   // Stimulus: directed table, then three random phases of differing idling
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         push_request(VECTORS[i].req, VECTORS[i].typed, VECTORS[i].res);
         sender_gap();
      end

      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 16; recv_idle_pct = 47; end
            1: begin send_idle_pct = 47; recv_idle_pct = 16; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int i = 0; i < N_RANDOM / 3; i++) begin
            push_request(random_request(), 1'b0, NO_RESULT);
            sender_gap();
         end
      end
      req_valid <= 1'b0;

      // drain, then allow for anything still in the pipeline
      while (pending_quats.size() != 0) @(posedge clock);
      repeat (PIPE_STAGES + 8) @(posedge clock);

      $display("Sent %0d requests (%0d directed, rest random over three idling phases);",
               sent_count, N_DIRECTED);
      $display("checked %0d responses, %0d of them saturated.", checked_count, clipped_count);
      if (error_count == 0) begin
         $display("quaternion_rate_integration_core: match");
      end else begin
         $display("quaternion_rate_integration_core: mismatch");
      end
      $finish;
   end

endmodule
